/* sv/assert_macros.svh */
// Assertion helper macros for the range max subarray tree block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/rmst_pkg.sv */
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants
// Node record type, merge function and sequencer states for the
// range maximum subarray tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int SUM_W = 26;
    localparam int NODE_W = 4 * SUM_W;

    typedef logic signed [SUM_W-1:0] t_sum;

    // one tree node: total, inner, suffix, prefix
    typedef struct packed {
        t_sum tot;
        t_sum inn;
        t_sum suf;
        t_sum pre;
    } t_node;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WLEAF,
        ST_WRD_L,
        ST_WRD_R,
        ST_WWAIT,
        ST_WMERGE,
        ST_QSTEP,
        ST_QWAIT,
        ST_QJOIN,
        ST_QDONE,
        ST_OUT
    } t_state;

    function automatic t_sum max2(input t_sum a, input t_sum b);
        return (a > b) ? a : b;
    endfunction

    // segment merge of left span a and right span b
    function automatic t_node join_spans(input t_node a, input t_node b);
        t_node m;
        m.tot = a.tot + b.tot;
        m.pre = max2(a.pre, a.tot + b.pre);
        m.suf = max2(b.suf, b.tot + a.suf);
        m.inn = max2(max2(a.inn, b.inn), a.suf + b.pre);
        return m;
    endfunction

endpackage

/* sv/range_max_subarray_tree_unit.sv */
// Write: the leaf is written, then each level up reads both children and writes their merge.
// Query: up to 2 node reads per level, each joined into the left or right accumulator;
// a rejected query goes straight to the output register.
// Cost set by the single node store port.
// Result is held in an output register; the next item is accepted after it leaves.
// After reset a clearing pass writes all 2*MAX_LEAVES nodes to zero, one per
// cycle, and no item is accepted meanwhile.
// ----------------------------------------------------------------------------
// range_max_subarray_tree_unit: segment tree for range maximum subarray sum
// Point writes and range queries over signed samples, one node access per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module range_max_subarray_tree_unit #(
    parameter int MAX_LEAVES  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: first_index[9:0], last_index[19:10], sample_value[35:20], zero pad
    input  logic [39:0] s_axis_tdata,
    // tuser: mode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: best_sum[25:0], zero pad
    output logic [31:0] m_axis_tdata,
    // tuser: range_ok
    output logic        m_axis_tuser
);

    localparam int LW = $clog2(MAX_LEAVES);
    localparam int AW = LW + 1;
    // query bounds need one more bit: the right bound can reach 2*MAX_LEAVES
    localparam int PW = AW + 1;

    rmst_pkg::t_state r_state, n_state;
    logic [10:0] r_len;
    logic [AW-1:0] r_k, n_k;
    logic [PW-1:0] r_lo, r_hi, n_lo, n_hi;
    logic r_have_l, r_have_r, r_side_r, n_have_l, n_have_r, n_side_r;
    rmst_pkg::t_node r_acc_l, r_acc_r, r_tmp, n_acc_l, n_acc_r, n_tmp;
    logic signed [rmst_pkg::SUM_W-1:0] r_best, n_best;
    logic r_ok, n_ok;
    logic [LW-1:0] in_first, in_last;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    rmst_pkg::t_node    ram_wdata, ram_rdata;
    logic [rmst_pkg::SUM_W-1:0] sample_ext;
    logic [10:0] limit;
    logic in_valid_w, in_valid_q;

    assign in_first = s_axis_tdata[LW-1:0];
    assign in_last  = s_axis_tdata[10+LW-1:10];
    assign sample_ext = rmst_pkg::SUM_W'($signed(s_axis_tdata[20+SAMPLE_BITS-1:20]));
    assign limit = (r_len > 11'(MAX_LEAVES)) ? 11'(MAX_LEAVES) : r_len;
    assign in_valid_w = (11'(s_axis_tdata[9:0]) < limit);
    assign in_valid_q = (s_axis_tdata[9:0] <= s_axis_tdata[19:10])
                     && (11'(s_axis_tdata[19:10]) < limit);

    rmst_ram #(.WIDTH(rmst_pkg::NODE_W), .DEPTH(2*MAX_LEAVES)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    wire accept = s_axis_tvalid && s_axis_tready;
    rmst_pkg::t_node merged;
    assign merged = r_side_r ? rmst_pkg::join_spans(ram_rdata, r_acc_r)
                             : rmst_pkg::join_spans(r_acc_l, ram_rdata);

    // next-state and datapath
    always_comb begin
        n_state = r_state; n_lo = r_lo; n_hi = r_hi; n_k = r_k;
        n_have_l = r_have_l; n_have_r = r_have_r; n_side_r = r_side_r;
        n_acc_l = r_acc_l; n_acc_r = r_acc_r; n_tmp = r_tmp;
        n_best = r_best; n_ok = r_ok;
        unique case (r_state)
            rmst_pkg::ST_CLEAR: begin
                n_k = r_k + 1'b1;
                if (r_k == AW'(2*MAX_LEAVES-1)) n_state = rmst_pkg::ST_IDLE;
            end
            rmst_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!s_axis_tuser) begin
                        n_k = {1'b1, in_first};
                        n_tmp = '{tot: sample_ext, inn: sample_ext,
                                  suf: sample_ext, pre: sample_ext};
                        if (in_valid_w) n_state = rmst_pkg::ST_WLEAF;
                    end else if (!in_valid_q) begin
                        n_ok = 1'b0; n_best = '0;
                        n_state = rmst_pkg::ST_OUT;
                    end else begin
                        n_lo = PW'({1'b1, in_first});
                        n_hi = PW'({1'b1, in_last}) + 1'b1;
                        n_have_l = 1'b0; n_have_r = 1'b0;
                        n_state = rmst_pkg::ST_QSTEP;
                    end
                end
            end
            rmst_pkg::ST_WLEAF, rmst_pkg::ST_WMERGE: begin
                if (r_k == AW'(1)) n_state = rmst_pkg::ST_IDLE;
                else begin
                    n_k = r_k >> 1;
                    n_state = rmst_pkg::ST_WRD_L;
                end
            end
            rmst_pkg::ST_WRD_L: n_state = rmst_pkg::ST_WRD_R;
            rmst_pkg::ST_WRD_R: begin
                n_acc_l = ram_rdata;
                n_state = rmst_pkg::ST_WWAIT;
            end
            rmst_pkg::ST_WWAIT: begin
                n_tmp = rmst_pkg::join_spans(r_acc_l, ram_rdata);
                n_state = rmst_pkg::ST_WMERGE;
            end
            rmst_pkg::ST_QSTEP: begin
                if (r_lo >= r_hi) n_state = rmst_pkg::ST_QDONE;
                else if (r_lo[0]) begin
                    n_side_r = 1'b0; n_k = r_lo[AW-1:0]; n_lo = r_lo + 1'b1;
                    n_state = rmst_pkg::ST_QWAIT;
                end else if (r_hi[0]) begin
                    n_side_r = 1'b1; n_hi = r_hi - 1'b1; n_k = AW'(r_hi - 1'b1);
                    n_state = rmst_pkg::ST_QWAIT;
                end else begin
                    n_lo = r_lo >> 1; n_hi = r_hi >> 1;
                end
            end
            rmst_pkg::ST_QWAIT: n_state = rmst_pkg::ST_QJOIN;
            rmst_pkg::ST_QJOIN: begin
                if (r_side_r) begin
                    n_acc_r = r_have_r ? merged : ram_rdata; n_have_r = 1'b1;
                end else begin
                    n_acc_l = r_have_l ? merged : ram_rdata; n_have_l = 1'b1;
                end
                n_state = rmst_pkg::ST_QSTEP;
            end
            rmst_pkg::ST_QDONE: begin
                n_tmp = (r_have_l && r_have_r) ? rmst_pkg::join_spans(r_acc_l, r_acc_r)
                      : (r_have_l ? r_acc_l : r_acc_r);
                n_best = n_tmp.inn; n_ok = 1'b1;
                n_state = rmst_pkg::ST_OUT;
            end
            rmst_pkg::ST_OUT: if (m_axis_tready) n_state = rmst_pkg::ST_IDLE;
            default: n_state = rmst_pkg::ST_IDLE;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        ram_we = 1'b0; ram_addr = r_k; ram_wdata = r_tmp;
        unique case (r_state)
            rmst_pkg::ST_CLEAR: begin ram_we = 1'b1; ram_wdata = '0; end
            rmst_pkg::ST_WLEAF, rmst_pkg::ST_WMERGE: ram_we = 1'b1;
            rmst_pkg::ST_WRD_L: ram_addr = {r_k[AW-2:0], 1'b0};
            rmst_pkg::ST_WRD_R: ram_addr = {r_k[AW-2:0], 1'b1};
            default: ram_addr = r_k;
        endcase
        s_axis_tready = (r_state == rmst_pkg::ST_IDLE);
        m_axis_tvalid = (r_state == rmst_pkg::ST_OUT);
        m_axis_tdata  = {6'd0, r_best};
        m_axis_tuser  = r_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmst_pkg::ST_CLEAR;
            r_k <= '0;
            r_len <= 11'd1024;
        end else begin
            r_state <= n_state;
            r_k <= n_k;
            if (i_cfg_we) r_len <= i_cfg_wdata;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_have_l <= n_have_l; r_have_r <= n_have_r;
        r_side_r <= n_side_r; r_acc_l <= n_acc_l; r_acc_r <= n_acc_r;
        r_tmp <= n_tmp; r_best <= n_best; r_ok <= n_ok;
    end

    `ASSERT_CLK(a_rej_zero, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0), "rejected query with nonzero sum")
    `ASSERT_CLK(a_no_overlap, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "input taken while result pending")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")

endmodule

/* sv/rmst_ram.sv */
// ----------------------------------------------------------------------------
// rmst_ram: generic single-port RAM
// One write or one read per cycle; registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write-first not needed: read data from a write cycle is never used by the tree unit
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
